// ----- rtl/sra_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the sensor range alarm escalator.
// No dependencies; used by every other file of the block.
package sra_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EVAL,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    CH_TEMP,
    CH_HUM,
    CH_SOIL
  } chan_t;

  typedef enum logic [1:0] {
    LVL_NONE,
    LVL_LEVE,
    LVL_MEDIA,
    LVL_GRAVE
  } level_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic step;
  } moist_ctl_t;

  typedef struct packed {
    logic  step;
    chan_t ch;
    logic  en;
  } alarm_ctl_t;

  localparam int NUM_CH    = 3;
  localparam int QW        = 10;
  localparam int DIV_STEPS = QW;
  localparam int CMP_W     = 12;
  localparam int FIELD_ADC = 12;

  localparam logic [QW-1:0] MOIST_FULL = 10'd1000;

  localparam int TICK_MS       = 5000;
  localparam int LEVE_SAMPLES  = 300000 / TICK_MS;
  localparam int MEDIA_SAMPLES = 1200000 / TICK_MS;
  localparam int GRAVE_SAMPLES = 3600000 / TICK_MS;

  localparam logic signed [10:0] TEMP_LOW  = -11'sd400;
  localparam logic signed [10:0] TEMP_HIGH = 11'sd800;
  localparam logic [10:0]        HUM_HIGH  = 11'd1000;

  localparam logic [2:0] REG_TEMP_MIN = 3'd0;
  localparam logic [2:0] REG_TEMP_MAX = 3'd1;
  localparam logic [2:0] REG_HUM_MIN  = 3'd2;
  localparam logic [2:0] REG_HUM_MAX  = 3'd3;
  localparam logic [2:0] REG_SOIL_MIN = 3'd4;
  localparam logic [2:0] REG_SOIL_MAX = 3'd5;
  localparam logic [2:0] REG_DRY_CAL  = 3'd6;
  localparam logic [2:0] REG_WET_CAL  = 3'd7;

  localparam logic signed [10:0] RST_TEMP_MIN = 11'sd100;
  localparam logic signed [10:0] RST_TEMP_MAX = 11'sd400;
  localparam logic [9:0]         RST_HUM_MIN  = 10'd300;
  localparam logic [9:0]         RST_HUM_MAX  = 10'd900;
  localparam logic [9:0]         RST_SOIL_MIN = 10'd200;
  localparam logic [9:0]         RST_SOIL_MAX = 10'd950;
  localparam logic [11:0]        RST_DRY_CAL  = 12'd4095;
  localparam logic [11:0]        RST_WET_CAL  = 12'd1500;

endpackage

// ----- rtl/sra_moist.sv -----
`timescale 1ns / 1ps
// Soil moisture unit: sign/clamp decode, one constant multiply and an
// iterative restoring divider, one quotient bit per step. Uses sra_pkg.
module sra_moist #(
  parameter int AW = 12
) (
  input  logic                     clk,
  input  sra_pkg::moist_ctl_t      ctl,
  input  logic [AW-1:0]            raw,
  input  logic [AW-1:0]            dry,
  input  logic [AW-1:0]            wet,
  output logic [sra_pkg::QW-1:0]   moist
);

  localparam int QW = sra_pkg::QW;
  localparam int PW = AW + QW;

  logic signed [AW:0] num;
  logic signed [AW:0] den;
  logic [AW:0]        num_mag;
  logic [AW:0]        den_mag;
  logic [AW-1:0]      abs_n;
  logic [AW-1:0]      abs_d;
  logic               zero_q;
  logic               full_q;
  logic [AW-1:0]      rem;
  logic [QW-1:0]      quo;
  logic [PW-1:0]      prod;
  logic [AW:0]        trial;
  logic [AW:0]        diff;
  logic               ge;

  assign num     = $signed({1'b0, dry}) - $signed({1'b0, raw});
  assign den     = $signed({1'b0, dry}) - $signed({1'b0, wet});
  assign num_mag = num[AW] ? (~num + 1'b1) : num;
  assign den_mag = den[AW] ? (~den + 1'b1) : den;

  assign prod  = {{QW{1'b0}}, abs_n} * PW'(sra_pkg::MOIST_FULL);
  assign trial = {rem, quo[QW-1]};
  assign ge    = trial >= {1'b0, abs_d};
  assign diff  = trial - {1'b0, abs_d};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      abs_n  <= num_mag[AW-1:0];
      abs_d  <= den_mag[AW-1:0];
      zero_q <= (den == '0) || (num == '0) || (num[AW] != den[AW]);
      full_q <= num_mag >= den_mag;
    end
    if (ctl.mul) begin
      rem <= prod[PW-1:QW];
      quo <= prod[QW-1:0];
    end else if (ctl.step) begin
      rem <= ge ? diff[AW-1:0] : trial[AW-1:0];
      quo <= {quo[QW-2:0], ge};
    end
  end

  assign moist = zero_q ? '0 : (full_q ? sra_pkg::MOIST_FULL : quo);

endmodule

// ----- rtl/sra_alarm.sv -----
`timescale 1ns / 1ps
// Alarm counter bank: one shared range compare and saturating increment,
// applied to one channel per step. Uses sra_pkg.
module sra_alarm #(
  parameter int CW = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  sra_pkg::alarm_ctl_t                     ctl,
  input  logic signed [sra_pkg::CMP_W-1:0]        val,
  input  logic signed [sra_pkg::CMP_W-1:0]        lo,
  input  logic signed [sra_pkg::CMP_W-1:0]        hi,
  output logic [sra_pkg::NUM_CH-1:0][15:0]        counts,
  output logic [sra_pkg::NUM_CH-1:0][1:0]         levels
);

  localparam int NCH = sra_pkg::NUM_CH;

  logic [CW-1:0]     cnt [NCH];
  sra_pkg::level_t   lvl [NCH];
  logic [CW-1:0]     cur;
  logic [CW-1:0]     cnt_next;
  logic              in_range;
  sra_pkg::level_t   lvl_next;
  logic [CW+15:0]    ext [NCH];

  always_comb begin
    cur = '0;
    for (int i = 0; i < NCH; i++) begin
      if (ctl.ch == sra_pkg::chan_t'(i)) cur = cnt[i];
    end
  end

  assign in_range = (val >= lo) && (val <= hi);

  always_comb begin
    if (in_range) cnt_next = '0;
    else if (&cur) cnt_next = cur;
    else cnt_next = cur + 1'b1;
  end

  always_comb begin
    if (cnt_next >= CW'(sra_pkg::GRAVE_SAMPLES)) lvl_next = sra_pkg::LVL_GRAVE;
    else if (cnt_next >= CW'(sra_pkg::MEDIA_SAMPLES)) lvl_next = sra_pkg::LVL_MEDIA;
    else if (cnt_next >= CW'(sra_pkg::LEVE_SAMPLES)) lvl_next = sra_pkg::LVL_LEVE;
    else lvl_next = sra_pkg::LVL_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCH; i++) begin
        cnt[i] <= '0;
        lvl[i] <= sra_pkg::LVL_NONE;
      end
    end else if (ctl.step) begin
      for (int i = 0; i < NCH; i++) begin
        if (ctl.ch == sra_pkg::chan_t'(i)) begin
          if (ctl.en) begin
            cnt[i] <= cnt_next;
            lvl[i] <= lvl_next;
          end else begin
            lvl[i] <= sra_pkg::LVL_NONE;
          end
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      ext[i]    = {16'b0, cnt[i]};
      counts[i] = ext[i][15:0];
      levels[i] = lvl[i];
    end
  end

  a_temp_lvl: assert property (@(posedge clk) disable iff (rst)
    (lvl[0] != sra_pkg::LVL_NONE) |-> (cnt[0] >= CW'(sra_pkg::LEVE_SAMPLES)))
    else $error("temperature level set below threshold");

  a_hum_lvl: assert property (@(posedge clk) disable iff (rst)
    (lvl[1] != sra_pkg::LVL_NONE) |-> (cnt[1] >= CW'(sra_pkg::LEVE_SAMPLES)))
    else $error("humidity level set below threshold");

  a_soil_grave: assert property (@(posedge clk) disable iff (rst)
    (lvl[2] == sra_pkg::LVL_GRAVE) |-> (cnt[2] >= CW'(sra_pkg::GRAVE_SAMPLES)))
    else $error("soil grave level below threshold");

endmodule

// ----- rtl/sensor_range_alarm_escalator.sv -----
`timescale 1ns / 1ps
// Top level of the sensor range alarm escalator: configuration registers,
// held sensor pair, sequencer and output register. Uses sra_pkg, sra_moist,
// sra_alarm.
//
// Usage: one sensor sample enters on the s_ stream, one result leaves on the
// m_ stream for every sample. Limits and soil calibration are written on the
// cfg port (index 0..7: temp_min, temp_max, hum_min, hum_max, soil_min,
// soil_max, soil_dry_cal, soil_wet_cal); cfg_ready is always high.
// Sequence: after acceptance the sequencer performs the constant multiply,
// then runs the divider (one quotient bit per step), then the shared
// compare/counter unit over the temperature, humidity and soil channels
// in turn, and finally loads the output register.
// s_tready is high only while the sequencer is idle.
// Reset: limits and calibration return to their defaults, held values and
// counters clear, no result is pending.
// Stall: a result waits in the output register; the next item is fully
// processed and then holds in its last step until the register frees.
module sensor_range_alarm_escalator #(
  parameter int ADC_BITS    = 12,
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // temp_tenths[10:0], hum_tenths[21:11], soil_raw[33:22], 0
  input  logic [1:0]  s_tuser,   // dht_ok[0], alerts_enabled[1]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // held_temp, held_hum, moisture_tenths, temp_level,
                                 // hum_level, soil_level, temp_count, hum_count,
                                 // soil_count, 0 pad
  output logic [0:0]  m_tuser,   // dht_rejected[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int AW = (ADC_BITS < sra_pkg::FIELD_ADC) ? ADC_BITS : sra_pkg::FIELD_ADC;
  localparam int NCH = sra_pkg::NUM_CH;

  logic signed [10:0] temp_min;
  logic signed [10:0] temp_max;
  logic [9:0]         hum_min;
  logic [9:0]         hum_max;
  logic [9:0]         soil_min;
  logic [9:0]         soil_max;
  logic [11:0]        dry_cal;
  logic [11:0]        wet_cal;

  logic signed [10:0] in_temp;
  logic [10:0]        in_hum;
  logic [11:0]        in_soil;
  logic               dht_accept;

  logic signed [10:0] held_temp;
  logic [9:0]         held_hum;
  logic               rejected;
  logic               en_q;

  sra_pkg::state_t     state;
  sra_pkg::state_t     state_next;
  logic [3:0]          step_cnt;
  sra_pkg::moist_ctl_t mctl;
  sra_pkg::alarm_ctl_t actl;
  logic                out_load;

  logic [sra_pkg::QW-1:0]              moist;
  logic signed [sra_pkg::CMP_W-1:0]    cmp_val;
  logic signed [sra_pkg::CMP_W-1:0]    cmp_lo;
  logic signed [sra_pkg::CMP_W-1:0]    cmp_hi;
  logic [NCH-1:0][15:0]                counts;
  logic [NCH-1:0][1:0]                 levels;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_min <= sra_pkg::RST_TEMP_MIN;
      temp_max <= sra_pkg::RST_TEMP_MAX;
      hum_min  <= sra_pkg::RST_HUM_MIN;
      hum_max  <= sra_pkg::RST_HUM_MAX;
      soil_min <= sra_pkg::RST_SOIL_MIN;
      soil_max <= sra_pkg::RST_SOIL_MAX;
      dry_cal  <= sra_pkg::RST_DRY_CAL;
      wet_cal  <= sra_pkg::RST_WET_CAL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sra_pkg::REG_TEMP_MIN: temp_min <= cfg_data[10:0];
        sra_pkg::REG_TEMP_MAX: temp_max <= cfg_data[10:0];
        sra_pkg::REG_HUM_MIN:  hum_min  <= cfg_data[9:0];
        sra_pkg::REG_HUM_MAX:  hum_max  <= cfg_data[9:0];
        sra_pkg::REG_SOIL_MIN: soil_min <= cfg_data[9:0];
        sra_pkg::REG_SOIL_MAX: soil_max <= cfg_data[9:0];
        sra_pkg::REG_DRY_CAL:  dry_cal  <= cfg_data;
        sra_pkg::REG_WET_CAL:  wet_cal  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_temp = s_tdata[10:0];
  assign in_hum  = s_tdata[21:11];
  assign in_soil = s_tdata[33:22];
  assign dht_accept = s_tuser[0] && (in_temp >= sra_pkg::TEMP_LOW) &&
                      (in_temp <= sra_pkg::TEMP_HIGH) && (in_hum <= sra_pkg::HUM_HIGH);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_temp <= '0;
      held_hum  <= '0;
    end else if (s_tvalid && s_tready && dht_accept) begin
      held_temp <= in_temp;
      held_hum  <= in_hum[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      rejected <= !dht_accept;
      en_q     <= s_tuser[1];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sra_pkg::ST_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= (state != state_next) ? '0 : step_cnt + 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sra_pkg::ST_IDLE: if (s_tvalid) state_next = sra_pkg::ST_MUL;
      sra_pkg::ST_MUL:  state_next = sra_pkg::ST_DIV;
      sra_pkg::ST_DIV: begin
        if (step_cnt == 4'(sra_pkg::DIV_STEPS - 1)) state_next = sra_pkg::ST_EVAL;
      end
      sra_pkg::ST_EVAL: begin
        if (step_cnt == 4'(NCH - 1)) state_next = sra_pkg::ST_DONE;
      end
      sra_pkg::ST_DONE: if (!m_tvalid || m_tready) state_next = sra_pkg::ST_IDLE;
      default: state_next = sra_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    mctl      = '0;
    actl.step = 1'b0;
    actl.ch   = sra_pkg::chan_t'(step_cnt[1:0]);
    actl.en   = en_q;
    out_load  = 1'b0;
    unique case (state)
      sra_pkg::ST_IDLE: begin
        s_tready  = 1'b1;
        mctl.load = s_tvalid;
      end
      sra_pkg::ST_MUL:  mctl.mul  = 1'b1;
      sra_pkg::ST_DIV:  mctl.step = 1'b1;
      sra_pkg::ST_EVAL: actl.step = 1'b1;
      sra_pkg::ST_DONE: out_load  = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  sra_moist #(
    .AW(AW)
  ) u_moist (
    .clk  (clk),
    .ctl  (mctl),
    .raw  (in_soil[AW-1:0]),
    .dry  (dry_cal[AW-1:0]),
    .wet  (wet_cal[AW-1:0]),
    .moist(moist)
  );

  always_comb begin
    unique case (actl.ch)
      sra_pkg::CH_TEMP: begin
        cmp_val = sra_pkg::CMP_W'(held_temp);
        cmp_lo  = sra_pkg::CMP_W'(temp_min);
        cmp_hi  = sra_pkg::CMP_W'(temp_max);
      end
      sra_pkg::CH_HUM: begin
        cmp_val = $signed({2'b0, held_hum});
        cmp_lo  = $signed({2'b0, hum_min});
        cmp_hi  = $signed({2'b0, hum_max});
      end
      sra_pkg::CH_SOIL: begin
        cmp_val = $signed({2'b0, moist});
        cmp_lo  = $signed({2'b0, soil_min});
        cmp_hi  = $signed({2'b0, soil_max});
      end
      default: begin
        cmp_val = '0;
        cmp_lo  = '0;
        cmp_hi  = '0;
      end
    endcase
  end

  sra_alarm #(
    .CW(COUNT_WIDTH)
  ) u_alarm (
    .clk   (clk),
    .rst   (rst),
    .ctl   (actl),
    .val   (cmp_val),
    .lo    (cmp_lo),
    .hi    (cmp_hi),
    .counts(counts),
    .levels(levels)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {3'b0, counts[2], counts[1], counts[0], levels[2], levels[1], levels[0],
                  moist, held_hum, held_temp};
      m_tuser <= rejected;
    end
  end

  a_moist_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[30:21] <= sra_pkg::MOIST_FULL))
    else $error("moisture above full scale");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == sra_pkg::ST_DONE))
    else $error("result raised outside final step");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("result changed while stalled");

endmodule
